[rtl/core/xxkd_pkg.sv]
// Shared types, constants and the XXTEA mixing function for the keystream word decryptor.
package xxkd_pkg;

    localparam int unsigned KEY_WORDS_DEF     = 1024;
    localparam int unsigned FULL_WORDS_DEF    = 512;
    localparam int unsigned SPARSE_STRIDE_DEF = 64;
    localparam int unsigned CHECK_WORDS_DEF   = 128;
    localparam int unsigned EXPAND_ROUNDS_DEF = 6;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [WORD_W-1:0] XXTEA_DELTA = 32'h9e37_79b9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_PART_ZERO  = 3'd0,
        REG_KEY_PART_ONE   = 3'd1,
        REG_KEY_PART_TWO   = 3'd2,
        REG_KEY_PART_THREE = 3'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_ROUND,
        ST_EXP_READ,
        ST_EXP_MIX,
        ST_EXP_WRITE,
        ST_DEC_READ,
        ST_DEC_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic exp_begin;
        logic exp_round;
        logic exp_read;
        logic exp_mix;
        logic exp_write;
        logic exp_finish;
        logic dec_read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic key_valid;
        logic step_last;
        logic round_last;
        logic out_free;
    } status_t;

    function automatic logic [WORD_W-1:0] xxtea_mix(
        input logic [WORD_W-1:0] y,
        input logic [WORD_W-1:0] z,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] key
    );
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (key ^ z);
        return a ^ b;
    endfunction

endpackage

[rtl/core/xxkd_ctrl.sv]
// Controller state machine sequencing keystream expansion and word decryption.
module xxkd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  xxkd_pkg::status_t status,
    output xxkd_pkg::cmd_t    cmd
);

    xxkd_pkg::state_t state_reg;
    xxkd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xxkd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            xxkd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.key_valid)
                    begin
                        state_next = xxkd_pkg::ST_DEC_READ;
                    end
                    else
                    begin
                        cmd.exp_begin = 1'b1;
                        state_next    = xxkd_pkg::ST_EXP_ROUND;
                    end
                end
            end
            xxkd_pkg::ST_EXP_ROUND:
            begin
                cmd.exp_round = 1'b1;
                state_next    = xxkd_pkg::ST_EXP_READ;
            end
            xxkd_pkg::ST_EXP_READ:
            begin
                cmd.exp_read = 1'b1;
                state_next   = xxkd_pkg::ST_EXP_MIX;
            end
            xxkd_pkg::ST_EXP_MIX:
            begin
                cmd.exp_mix = 1'b1;
                state_next  = xxkd_pkg::ST_EXP_WRITE;
            end
            xxkd_pkg::ST_EXP_WRITE:
            begin
                cmd.exp_write = 1'b1;
                priority if (!status.step_last)
                begin
                    state_next = xxkd_pkg::ST_EXP_READ;
                end
                else if (!status.round_last)
                begin
                    state_next = xxkd_pkg::ST_EXP_ROUND;
                end
                else
                begin
                    cmd.exp_finish = 1'b1;
                    state_next     = xxkd_pkg::ST_DEC_READ;
                end
            end
            xxkd_pkg::ST_DEC_READ:
            begin
                cmd.dec_read = 1'b1;
                state_next   = xxkd_pkg::ST_DEC_DONE;
            end
            xxkd_pkg::ST_DEC_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = xxkd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xxkd_pkg::ST_IDLE;
            end
        endcase
    end

    a_dec_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xxkd_pkg::ST_DEC_READ) |-> status.key_valid)
        else $error("decrypt read without a valid keystream");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xxkd_pkg::ST_DEC_DONE && status.out_free)
        |=> (state_reg == xxkd_pkg::ST_IDLE))
        else $error("result load did not return to idle");

    a_expand_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == xxkd_pkg::ST_EXP_ROUND) && $past(state_reg == xxkd_pkg::ST_IDLE)
        |-> $past(!status.key_valid))
        else $error("expansion started with a valid keystream");

endmodule

[rtl/core/xxkd_dp.sv]
// Datapath: key registers, keystream store, expansion arithmetic and word decryption.
module xxkd_dp #(
    parameter int unsigned KEY_WORDS     = xxkd_pkg::KEY_WORDS_DEF,
    parameter int unsigned FULL_WORDS    = xxkd_pkg::FULL_WORDS_DEF,
    parameter int unsigned SPARSE_STRIDE = xxkd_pkg::SPARSE_STRIDE_DEF,
    parameter int unsigned CHECK_WORDS   = xxkd_pkg::CHECK_WORDS_DEF,
    parameter int unsigned EXPAND_ROUNDS = xxkd_pkg::EXPAND_ROUNDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [xxkd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [xxkd_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                first_word,
    input  logic                                last_word,
    input  logic [xxkd_pkg::WORD_W-1:0]         cipher_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [xxkd_pkg::WORD_W-1:0]         plain_word,
    output logic                                was_decrypted,
    output logic [xxkd_pkg::WORD_W-1:0]         running_checksum,
    output logic                                end_of_buffer,
    input  xxkd_pkg::cmd_t                      cmd,
    output xxkd_pkg::status_t                   status
);

    localparam int unsigned POS_CAP = (FULL_WORDS > CHECK_WORDS) ? FULL_WORDS : CHECK_WORDS;
    localparam int unsigned AW      = $clog2(KEY_WORDS);
    localparam int unsigned PW      = $clog2(POS_CAP + 1);
    localparam int unsigned SW      = (SPARSE_STRIDE > 1) ? $clog2(SPARSE_STRIDE) : 1;
    localparam int unsigned RW      = $clog2(EXPAND_ROUNDS + 1);
    localparam int unsigned W       = xxkd_pkg::WORD_W;

    logic [W-1:0]  key_reg [4];
    logic          key_valid_reg;

    logic [W-1:0]  store_mem [KEY_WORDS];
    logic [W-1:0]  rdata_reg;
    logic [AW-1:0] raddr;
    logic          rd_en;

    logic [AW-1:0] step_reg;
    logic [RW-1:0] round_reg;
    logic [W-1:0]  sum_reg;
    logic [W-1:0]  z_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  old_reg;
    logic [W-1:0]  mix_reg;
    logic [W-1:0]  first_new_reg;
    logic [W-1:0]  y_sel;
    logic [W-1:0]  new_word;
    logic [1:0]    key_sel;

    logic          first_reg;
    logic          last_reg;
    logic [W-1:0]  cw_reg;
    logic [PW-1:0] pos_reg;
    logic [SW-1:0] phase_reg;
    logic [AW-1:0] ptr_reg;
    logic [W-1:0]  csum_reg;
    logic          dec_reg;
    logic          chk_reg;

    logic [PW-1:0] eff_pos;
    logic [SW-1:0] eff_phase;
    logic [AW-1:0] eff_ptr;
    logic          in_full;
    logic          dec;
    logic [W-1:0]  word_out;
    logic [W-1:0]  csum_new;

    logic          out_valid_reg;
    logic [W-1:0]  out_word_reg;
    logic          out_dec_reg;
    logic [W-1:0]  out_csum_reg;
    logic          out_last_reg;

    logic          step_last;

    assign cfg_ready = 1'b1;
    assign step_last = (step_reg == AW'(KEY_WORDS - 1));

    // key registers and keystream valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0]    <= '0;
            key_reg[1]    <= '0;
            key_reg[2]    <= '0;
            key_reg[3]    <= '0;
            key_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exp_finish)
            begin
                key_valid_reg <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    xxkd_pkg::REG_KEY_PART_ZERO,
                    xxkd_pkg::REG_KEY_PART_ONE,
                    xxkd_pkg::REG_KEY_PART_TWO,
                    xxkd_pkg::REG_KEY_PART_THREE:
                    begin
                        if (key_reg[cfg_index[1:0]] != cfg_data)
                        begin
                            key_reg[cfg_index[1:0]] <= cfg_data;
                            key_valid_reg           <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // keystream store
    assign rd_en = cmd.exp_read || cmd.dec_read;

    always_comb
    begin
        if (cmd.dec_read)
        begin
            raddr = eff_ptr;
        end
        else if (step_last)
        begin
            raddr = '0;
        end
        else
        begin
            raddr = step_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exp_write)
        begin
            store_mem[step_reg] <= new_word;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    // expansion: round zero reads as a cleared store
    assign key_sel = step_reg[1:0] ^ sum_reg[3:2];
    assign new_word = old_reg + mix_reg;

    always_comb
    begin
        if (step_last)
        begin
            y_sel = first_new_reg;
        end
        else if (round_reg == '0)
        begin
            y_sel = '0;
        end
        else
        begin
            y_sel = rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.exp_begin)
            begin
                round_reg <= '0;
            end
            if (cmd.exp_round)
            begin
                step_reg <= '0;
            end
            if (cmd.exp_write)
            begin
                if (step_last)
                begin
                    round_reg <= round_reg + RW'(1);
                end
                else
                begin
                    step_reg <= step_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exp_begin)
        begin
            sum_reg       <= '0;
            z_reg         <= '0;
            first_new_reg <= '0;
        end
        if (cmd.exp_round)
        begin
            sum_reg <= sum_reg + xxkd_pkg::XXTEA_DELTA;
            old_reg <= first_new_reg;
        end
        if (cmd.exp_mix)
        begin
            mix_reg <= xxkd_pkg::xxtea_mix(y_sel, z_reg, sum_reg, key_reg[key_sel]);
            y_reg   <= y_sel;
        end
        if (cmd.exp_write)
        begin
            z_reg   <= new_word;
            old_reg <= y_reg;
            if (step_reg == '0)
            begin
                first_new_reg <= new_word;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            first_reg <= first_word;
            last_reg  <= last_word;
            cw_reg    <= cipher_word;
        end
    end

    // position, stride and pointer tracking
    assign eff_pos   = first_reg ? '0 : pos_reg;
    assign eff_phase = first_reg ? '0 : phase_reg;
    assign eff_ptr   = first_reg ? '0 : ptr_reg;
    assign in_full   = (eff_pos < PW'(FULL_WORDS));
    assign dec       = in_full || (eff_phase == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= '0;
            ptr_reg   <= '0;
            csum_reg  <= '0;
            dec_reg   <= 1'b0;
            chk_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.dec_read)
            begin
                pos_reg <= (eff_pos < PW'(POS_CAP)) ? eff_pos + PW'(1) : eff_pos;
                if (in_full)
                begin
                    phase_reg <= eff_phase;
                end
                else if (eff_phase == SW'(SPARSE_STRIDE - 1))
                begin
                    phase_reg <= '0;
                end
                else
                begin
                    phase_reg <= eff_phase + SW'(1);
                end
                if (!dec)
                begin
                    ptr_reg <= eff_ptr;
                end
                else if (eff_ptr == AW'(KEY_WORDS - 1))
                begin
                    ptr_reg <= '0;
                end
                else
                begin
                    ptr_reg <= eff_ptr + AW'(1);
                end
                csum_reg <= first_reg ? '0 : csum_reg;
                dec_reg  <= dec;
                chk_reg  <= (eff_pos < PW'(CHECK_WORDS));
            end
            if (cmd.out_load)
            begin
                csum_reg <= csum_new;
            end
        end
    end

    assign word_out = cw_reg ^ (dec_reg ? rdata_reg : '0);
    assign csum_new = chk_reg ? (csum_reg ^ word_out) : csum_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word_reg <= word_out;
            out_dec_reg  <= dec_reg;
            out_csum_reg <= csum_new;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign plain_word       = out_word_reg;
    assign was_decrypted    = out_dec_reg;
    assign running_checksum = out_csum_reg;
    assign end_of_buffer    = out_last_reg;

    assign status.key_valid  = key_valid_reg;
    assign status.step_last  = step_last;
    assign status.round_last = (round_reg == RW'(EXPAND_ROUNDS - 1));
    assign status.out_free   = !out_valid_reg || !out_stall;

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= AW'(KEY_WORDS - 1))
        else $error("keystream pointer beyond store");

    a_pos_capped: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(POS_CAP))
        else $error("word position beyond cap");

    a_rounds_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exp_write |-> (round_reg < RW'(EXPAND_ROUNDS)))
        else $error("expansion ran past the last round");

endmodule

[rtl/core/xxkd_top_unused_guard.sv]
// Result-channel checker watching the output handshake at the ports.
module xxkd_top_unused_guard (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [xxkd_pkg::WORD_W-1:0] plain_word,
    input logic                        was_decrypted
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(plain_word))
        else $error("stalled result changed");

    a_plain_when_skipped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !was_decrypted) |-> !$isunknown(plain_word))
        else $error("undefined pass-through word");

endmodule

[rtl/core/xxtea_keystream_word_decrypt_core.sv]
// Top level of the XXTEA keystream word decryptor.
// Decrypts a buffer one 32-bit item at a time: the first FULL_WORDS items of a buffer are XORed
// with consecutive keystream words, then only every SPARSE_STRIDE-th item; the checksum covers the
// first CHECK_WORDS results. With a valid keystream an item passes accept, a registered read of
// the single keystream store and result load, held while the output is stalled. The first item
// after reset or after a key part changes first expands the store in place over EXPAND_ROUNDS
// rounds, stalling the input, with one read, mix and write-back per store word per round. A
// finished result waits in an output register while the next item is taken. The user must write
// key parts through the cfg port only while no item is in flight; the block does not enforce it.
module xxtea_keystream_word_decrypt_core #(
    parameter int unsigned KEY_WORDS     = xxkd_pkg::KEY_WORDS_DEF,
    parameter int unsigned FULL_WORDS    = xxkd_pkg::FULL_WORDS_DEF,
    parameter int unsigned SPARSE_STRIDE = xxkd_pkg::SPARSE_STRIDE_DEF,
    parameter int unsigned CHECK_WORDS   = xxkd_pkg::CHECK_WORDS_DEF,
    parameter int unsigned EXPAND_ROUNDS = xxkd_pkg::EXPAND_ROUNDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [xxkd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [xxkd_pkg::WORD_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             first_word,
    input  logic                             last_word,
    input  logic [xxkd_pkg::WORD_W-1:0]      cipher_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [xxkd_pkg::WORD_W-1:0]      plain_word,
    output logic                             was_decrypted,
    output logic [xxkd_pkg::WORD_W-1:0]      running_checksum,
    output logic                             end_of_buffer
);

    xxkd_pkg::cmd_t    cmd;
    xxkd_pkg::status_t status;

    xxkd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    xxkd_dp #(
        .KEY_WORDS     (KEY_WORDS),
        .FULL_WORDS    (FULL_WORDS),
        .SPARSE_STRIDE (SPARSE_STRIDE),
        .CHECK_WORDS   (CHECK_WORDS),
        .EXPAND_ROUNDS (EXPAND_ROUNDS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .first_word       (first_word),
        .last_word        (last_word),
        .cipher_word      (cipher_word),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .plain_word       (plain_word),
        .was_decrypted    (was_decrypted),
        .running_checksum (running_checksum),
        .end_of_buffer    (end_of_buffer),
        .cmd              (cmd),
        .status           (status)
    );

    xxkd_top_unused_guard u_out_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .plain_word    (plain_word),
        .was_decrypted (was_decrypted)
    );

endmodule

[test/tb_xxtea_keystream_word_decrypt_core.sv]
// Self-checking testbench for the XXTEA keystream word decryptor, predictor included.
`timescale 1ns / 100ps

module tb_xxtea_keystream_word_decrypt_core;

    localparam int unsigned WORD_W         = xxkd_pkg::WORD_W;
    localparam int unsigned CFG_INDEX_W    = xxkd_pkg::CFG_INDEX_W;
    localparam int unsigned KS_WORDS       = xxkd_pkg::KEY_WORDS_DEF;
    localparam int unsigned FULL_LEN       = xxkd_pkg::FULL_WORDS_DEF;
    localparam int unsigned STRIDE         = xxkd_pkg::SPARSE_STRIDE_DEF;
    localparam int unsigned CSUM_LEN       = xxkd_pkg::CHECK_WORDS_DEF;
    localparam int unsigned EXP_ROUNDS     = xxkd_pkg::EXPAND_ROUNDS_DEF;
    localparam int unsigned POS_CAP        = (FULL_LEN > CSUM_LEN) ? FULL_LEN : CSUM_LEN;
    localparam int unsigned RANDOM_ITEMS   = 1400;
    localparam int unsigned WATCHDOG_LIMIT = 100000;

    typedef struct {
        logic              is_first;
        logic              is_last;
        logic [WORD_W-1:0] word;
    } cipher_item_t;

    typedef struct {
        logic [WORD_W-1:0] plain;
        logic              decrypted;
        logic [WORD_W-1:0] checksum;
        logic              eob;
    } plain_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   first_word = 1'b0;
    logic                   last_word = 1'b0;
    logic [WORD_W-1:0]      cipher_word = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [WORD_W-1:0]      plain_word;
    logic                   was_decrypted;
    logic [WORD_W-1:0]      running_checksum;
    logic                   end_of_buffer;

    xxtea_keystream_word_decrypt_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .first_word       (first_word),
        .last_word        (last_word),
        .cipher_word      (cipher_word),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .plain_word       (plain_word),
        .was_decrypted    (was_decrypted),
        .running_checksum (running_checksum),
        .end_of_buffer    (end_of_buffer)
    );

    // Predictor state
    logic [WORD_W-1:0] key_word [4] = '{default: '0};
    logic [WORD_W-1:0] ks_store [KS_WORDS];
    logic              ks_ready = 1'b0;
    int unsigned       buf_pos = 0;
    int unsigned       sparse_phase = 0;
    int unsigned       ks_ptr = 0;
    logic [WORD_W-1:0] csum_acc = '0;

    cipher_item_t  pending_q [$];
    plain_result_t plain_q [$];
    logic          item_taken = 1'b0;
    int unsigned   send_idle_pct = 27;
    int unsigned   recv_idle_pct = 59;
    int unsigned   idle_cycles = 0;
    int unsigned   error_count = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] tea_term(input logic [WORD_W-1:0] y,
                                                   input logic [WORD_W-1:0] z,
                                                   input logic [WORD_W-1:0] sum,
                                                   input logic [WORD_W-1:0] k);
        return (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^ ((sum ^ y) + (k ^ z));
    endfunction

    function automatic void refill_keystream();
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [1:0]        e;
        for (int i = 0; i < KS_WORDS; i++) ks_store[i] = '0;
        sum = '0;
        z = '0;
        for (int r = 0; r < EXP_ROUNDS; r++)
        begin
            sum += xxkd_pkg::XXTEA_DELTA;
            e = sum[3:2];
            for (int p = 0; p < KS_WORDS; p++)
            begin
                y = ks_store[(p + 1) % KS_WORDS];
                ks_store[p] += tea_term(y, z, sum, key_word[p[1:0] ^ e]);
                z = ks_store[p];
            end
        end
        ks_ready = 1'b1;
    endfunction

    function automatic plain_result_t decrypt_word(input logic is_first, input logic is_last,
                                                   input logic [WORD_W-1:0] word);
        plain_result_t res;
        logic          apply;
        if (!ks_ready) refill_keystream();
        if (is_first)
        begin
            buf_pos = 0;
            sparse_phase = 0;
            ks_ptr = 0;
            csum_acc = '0;
        end
        if (buf_pos < FULL_LEN)
        begin
            apply = 1'b1;
        end
        else
        begin
            apply = (sparse_phase == 0);
            sparse_phase = (sparse_phase + 1 >= STRIDE) ? 0 : sparse_phase + 1;
        end
        if (apply)
        begin
            word ^= ks_store[ks_ptr];
            ks_ptr = (ks_ptr + 1 >= KS_WORDS) ? 0 : ks_ptr + 1;
        end
        if (buf_pos < CSUM_LEN) csum_acc ^= word;
        if (buf_pos < POS_CAP) buf_pos++;
        res.plain = word;
        res.decrypted = apply;
        res.checksum = csum_acc;
        res.eob = is_last;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Driver: hold a stalled item, otherwise load the next or idle
    always @(negedge clk)
    begin
        cipher_item_t nxt;
        if (!in_valid || item_taken)
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_q.pop_front();
                in_valid <= 1'b1;
                first_word <= nxt.is_first;
                last_word <= nxt.is_last;
                cipher_word <= nxt.word;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor, predictor hookup and watchdog
    always @(posedge clk)
    begin
        plain_result_t want;
        logic          out_taken;
        item_taken = in_valid && !in_stall;
        out_taken = out_valid && !out_stall;
        if (item_taken)
            plain_q.push_back(decrypt_word(first_word, last_word, cipher_word));
        if (out_taken)
        begin
            if (plain_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none actual %h", $time,
                         plain_word);
            end
            else
            begin
                want = plain_q.pop_front();
                check_field("plain_word", want.plain, plain_word);
                check_field("was_decrypted", WORD_W'(want.decrypted), WORD_W'(was_decrypted));
                check_field("running_checksum", want.checksum, running_checksum);
                check_field("end_of_buffer", WORD_W'(want.eob), WORD_W'(end_of_buffer));
            end
        end
        if (item_taken || out_taken || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("xxtea_keystream_word_decrypt_core verification failed");
            $finish;
        end
    end

    task automatic push_item(input logic is_first, input logic is_last,
                             input logic [WORD_W-1:0] word);
        cipher_item_t it;
        it.is_first = is_first;
        it.is_last = is_last;
        it.word = word;
        pending_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid || plain_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_key(input logic [CFG_INDEX_W-1:0] index,
                             input logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (index <= xxkd_pkg::REG_KEY_PART_THREE && key_word[index[1:0]] != value)
        begin
            key_word[index[1:0]] = value;
            ks_ready = 1'b0;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                           input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
        write_key(xxkd_pkg::REG_KEY_PART_ZERO, k0);
        write_key(xxkd_pkg::REG_KEY_PART_ONE, k1);
        write_key(xxkd_pkg::REG_KEY_PART_TWO, k2);
        write_key(xxkd_pkg::REG_KEY_PART_THREE, k3);
    endtask

    task automatic write_bad_index();
        write_key(CFG_INDEX_W'($urandom_range(2 ** CFG_INDEX_W - 1,
                                              xxkd_pkg::REG_KEY_PART_THREE + 1)),
                  $urandom());
    endtask

    // Mostly framed buffers, with restarts, stray last marks and unframed continuations
    task automatic queue_buffers(input int unsigned target);
        int unsigned count;
        int unsigned len;
        logic        is_first;
        logic        is_last;
        count = 0;
        while (count < target)
        begin
            len = ($urandom_range(99) < 12) ? $urandom_range(660, FULL_LEN + 1)
                                            : $urandom_range(48, 1);
            for (int unsigned i = 0; i < len; i++)
            begin
                if (i == 0)
                    is_first = ($urandom_range(99) < 90);
                else
                    is_first = ($urandom_range(99) < 2);
                if (i == len - 1)
                    is_last = ($urandom_range(99) < 90);
                else
                    is_last = ($urandom_range(99) < 3);
                push_item(is_first, is_last, $urandom());
            end
            count += len;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset key, no first mark after reset, continue past a last mark
        push_item(1'b0, 1'b0, 32'h0000_0000);
        push_item(1'b0, 1'b0, 32'hffff_ffff);
        push_item(1'b0, 1'b1, 32'haaaa_aaaa);
        push_item(1'b0, 1'b0, 32'h5555_5555);
        push_item(1'b1, 1'b0, 32'h8000_0000);
        push_item(1'b1, 1'b1, 32'h0000_0001);
        wait_idle();

        set_key('1, '1, '1, '1);
        write_key(xxkd_pkg::REG_KEY_PART_TWO, '1);
        write_bad_index();
        push_item(1'b1, 1'b0, 32'h0000_0000);
        push_item(1'b0, 1'b0, 32'hffff_ffff);
        push_item(1'b0, 1'b0, 32'h0f0f_0f0f);
        push_item(1'b0, 1'b1, 32'hf0f0_f0f0);
        push_item(1'b1, 1'b1, 32'h7fff_ffff);
        push_item(1'b0, 1'b0, 32'h1234_5678);
        wait_idle();

        write_key(xxkd_pkg::REG_KEY_PART_ONE, '0);
        write_key(xxkd_pkg::REG_KEY_PART_THREE, '0);
        push_item(1'b1, 1'b0, 32'hdead_beef);
        push_item(1'b0, 1'b0, 32'h0000_0000);
        push_item(1'b0, 1'b1, 32'hffff_ffff);
        push_item(1'b1, 1'b1, 32'h8000_0001);
        wait_idle();

        send_idle_pct = 27;
        recv_idle_pct = 59;
        set_key($urandom(), $urandom(), $urandom(), $urandom());
        queue_buffers(RANDOM_ITEMS / 6);
        // Hold the sender until every result is back
        wait_idle();
        queue_buffers(RANDOM_ITEMS / 6);
        wait_idle();

        send_idle_pct = 59;
        recv_idle_pct = 27;
        set_key($urandom(), $urandom(), $urandom(), $urandom());
        write_bad_index();
        queue_buffers(RANDOM_ITEMS / 3);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_key('0, '1, $urandom(), $urandom());
        queue_buffers(RANDOM_ITEMS / 3);
        wait_idle();

        repeat (20) @(negedge clk);
        if (plain_q.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, plain_q.size());
        end
        if (error_count == 0)
            $display("xxtea_keystream_word_decrypt_core verification clean");
        else
            $display("xxtea_keystream_word_decrypt_core verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/xxkd_pkg.sv
rtl/core/xxkd_ctrl.sv
rtl/core/xxkd_dp.sv
rtl/core/xxkd_top_unused_guard.sv
rtl/core/xxtea_keystream_word_decrypt_core.sv
test/tb_xxtea_keystream_word_decrypt_core.sv
